// ===== design/rxl_pkg.sv =====
// Shared constants, types and helper functions for the receive level estimator.
package rxl_pkg;

    localparam int LOG_FRAC_BITS = 8;

    localparam int NUM_W   = 34;                      // widest numerator: 3 * 65535^2
    localparam int POS_W   = 6;                       // leading-one position 0..33
    localparam int MANT_W  = 31;                      // Q30 mantissa in [1,2)
    localparam int LOG_W   = POS_W + LOG_FRAC_BITS;
    localparam int PROD_W  = LOG_W + 20;
    localparam int LEV_W   = PROD_W + 2;
    localparam int DB_SHIFT = 8 + LOG_FRAC_BITS;

    // normalise, leading-one, front stages, product and output around the squaring chain
    localparam int NUM_STAGES = LOG_FRAC_BITS + 6;
    localparam int SQ_FIRST   = 4;
    localparam int PROD_STAGE = SQ_FIRST + LOG_FRAC_BITS;
    localparam int OUT_STAGE  = PROD_STAGE + 1;

    localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd197283;   // 10*log10(2) in Q16
    localparam logic [15:0] OFFSET_RESET    = 16'd29125;
    localparam logic [7:0]  ADJUST_RESET    = 8'hFB;

    localparam logic signed [LEV_W-1:0] ROUND_HALF = LEV_W'(1) << (DB_SHIFT - 1);
    localparam logic signed [LEV_W-1:0] SAT_MAX    = LEV_W'(32767);
    localparam logic signed [LEV_W-1:0] SAT_MIN    = -LEV_W'(32768);

    typedef enum logic {
        REG_LEVEL_OFFSET = 1'b0,
        REG_COUNT_ADJUST = 1'b1
    } t_reg_idx;

    // one item as it travels through the squaring chain, both logarithms side by side
    typedef struct packed {
        logic                     inv;
        logic [POS_W-1:0]         pos_num;
        logic [POS_W-1:0]         pos_den;
        logic [MANT_W-1:0]        m_num;
        logic [MANT_W-1:0]        m_den;
        logic [LOG_FRAC_BITS-1:0] f_num;
        logic [LOG_FRAC_BITS-1:0] f_den;
    } t_sq_item;

    function automatic logic [POS_W-1:0] lead_one(input logic [NUM_W-1:0] x);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < NUM_W; i++) begin
            if (x[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    // x * 2^30 / 2^p, truncated to Q30
    function automatic logic [MANT_W-1:0] normalise(input logic [NUM_W-1:0] x,
                                                    input logic [POS_W-1:0] p);
        logic [NUM_W+MANT_W-2:0] w;
        w = {x, (MANT_W-1)'(0)} >> p;
        return w[MANT_W-1:0];
    endfunction

endpackage

// ===== design/rx_level_db_estimator_top.sv =====
// Top level of the receive level estimator: log-domain dB level from one diagnostic record.
//
// Input channel: i_valid / o_stall with the record fields as separate ports; a transfer
// happens on a rising edge with i_valid high and o_stall low. Output channel: o_valid /
// i_stall carrying o_level_db_q8 and o_invalid, one result per record, in order.
// Configuration: i_cfg_wr_en writes i_cfg_wdata into the register chosen by i_cfg_index
// (0 level offset, 1 count adjust); write only while no record is in flight.
// A record passes from input transfer through stages 0 to 3, the squaring chain, the product
// stage and the output stage to o_valid. Throughput is one record per cycle while i_stall is
// low: the fraction of each log2 comes from a chain of squaring stages, one fraction bit per
// stage, each with its own pair of 31x31 multipliers, so the chain never iterates.
// Reset (synchronous, active low) empties the pipeline and restores the offset to 29125
// and the count adjust to -5.
// When the receiver stalls, the result holds at the output and the stages behind it keep
// advancing into empty slots; o_stall rises only once every stage holds a record.
module rx_level_db_estimator_top
    import rxl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [15:0] i_cir_power,
    input  logic [15:0] i_path_amp_one,
    input  logic [15:0] i_path_amp_two,
    input  logic [15:0] i_path_amp_three,
    input  logic [11:0] i_preamble_count,
    input  logic [11:0] i_preamble_count_nosat,

    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_level_db_q8,
    output logic        o_invalid
);

    logic [15:0]           r_offset;
    logic [7:0]            r_adj;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES:0]   en;

    // stage 0: squares and corrected count
    logic        r_s0_op;
    logic [15:0] r_s0_cir;
    logic [31:0] r_s0_sq1, r_s0_sq2, r_s0_sq3;
    logic [13:0] r_s0_n;
    logic [13:0] n_s0_n;

    // stage 1: numerator, denominator, invalid
    logic [NUM_W-1:0] r_s1_num, r_s1_nsq;
    logic             r_s1_inv;
    logic [NUM_W-1:0] n_s1_num;
    logic [25:0]      n_s1_nsq;

    // stage 2: leading-one positions
    logic [NUM_W-1:0] r_s2_num, r_s2_nsq;
    logic [POS_W-1:0] r_s2_pn, r_s2_pd;
    logic             r_s2_inv;

    // stage 3 onwards: normalised mantissas and squaring chain
    t_sq_item r_sq0;
    t_sq_item sq_item [0:LOG_FRAC_BITS];

    // product and output stages
    logic [LOG_W-1:0]          log_num, log_den;
    logic signed [LOG_W:0]     diff;
    logic signed [PROD_W-1:0]  diff_w, db_w, n_prod, r_prod;
    logic                      r_pinv;
    logic signed [LEV_W-1:0]   sum, shifted, level;
    logic [15:0]               n_level, r_level;
    logic                      r_out_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
            r_adj    <= ADJUST_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_LEVEL_OFFSET: r_offset <= i_cfg_wdata;
                REG_COUNT_ADJUST: r_adj    <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // a stage advances when it is empty or the one after it advances
    always_comb begin
        en[NUM_STAGES] = !i_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0
    assign n_s0_n = {2'b00, i_preamble_count}
                  + ((i_preamble_count == i_preamble_count_nosat) ?
                     {{6{r_adj[7]}}, r_adj} : 14'd0);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_op  <= i_opcode;
            r_s0_cir <= i_cir_power;
            r_s0_sq1 <= 32'(i_path_amp_one)   * 32'(i_path_amp_one);
            r_s0_sq2 <= 32'(i_path_amp_two)   * 32'(i_path_amp_two);
            r_s0_sq3 <= 32'(i_path_amp_three) * 32'(i_path_amp_three);
            r_s0_n   <= n_s0_n;
        end
    end

    // stage 1
    always_comb begin
        if (r_s0_op) begin
            n_s1_num = NUM_W'(r_s0_sq1) + NUM_W'(r_s0_sq2) + NUM_W'(r_s0_sq3);
        end else begin
            n_s1_num = {1'b0, r_s0_cir, 17'd0};
        end
        n_s1_nsq = 26'(r_s0_n[12:0]) * 26'(r_s0_n[12:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_num <= n_s1_num;
            r_s1_nsq <= NUM_W'(n_s1_nsq);
            r_s1_inv <= r_s0_n[13] || (r_s0_n == 14'd0) || (n_s1_num == '0);
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_num <= r_s1_num;
            r_s2_nsq <= r_s1_nsq;
            r_s2_pn  <= lead_one(r_s1_num);
            r_s2_pd  <= lead_one(r_s1_nsq);
            r_s2_inv <= r_s1_inv;
        end
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_sq0.inv     <= r_s2_inv;
            r_sq0.pos_num <= r_s2_pn;
            r_sq0.pos_den <= r_s2_pd;
            r_sq0.m_num   <= normalise(r_s2_num, r_s2_pn);
            r_sq0.m_den   <= normalise(r_s2_nsq, r_s2_pd);
            r_sq0.f_num   <= '0;
            r_sq0.f_den   <= '0;
        end
    end

    assign sq_item[0] = r_sq0;

    for (genvar g = 0; g < LOG_FRAC_BITS; g++) begin : g_sq
        rxl_sq_stage u_sq (
            .i_clk  (i_clk),
            .i_en   (en[SQ_FIRST + g]),
            .i_item (sq_item[g]),
            .o_item (sq_item[g+1])
        );
    end

    // product stage
    always_comb begin
        log_num = {sq_item[LOG_FRAC_BITS].pos_num, sq_item[LOG_FRAC_BITS].f_num};
        log_den = {sq_item[LOG_FRAC_BITS].pos_den, sq_item[LOG_FRAC_BITS].f_den};
        diff    = $signed({1'b0, log_num}) - $signed({1'b0, log_den});
        diff_w  = PROD_W'(diff);
        db_w    = $signed(PROD_W'(DB_PER_LOG2_Q16));
        n_prod  = diff_w * db_w;
    end

    always_ff @(posedge i_clk) begin
        if (en[PROD_STAGE]) begin
            r_prod <= n_prod;
            r_pinv <= sq_item[LOG_FRAC_BITS].inv;
        end
    end

    // output stage: round half up, subtract offset, saturate; an invalid record gives 16'h8000
    always_comb begin
        sum     = LEV_W'(r_prod) + ROUND_HALF;
        shifted = sum >>> DB_SHIFT;
        level   = shifted - $signed(LEV_W'(r_offset));
        if (r_pinv) begin
            n_level = 16'h8000;
        end else if (level > SAT_MAX) begin
            n_level = 16'h7FFF;
        end else if (level < SAT_MIN) begin
            n_level = 16'h8000;
        end else begin
            n_level = level[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[OUT_STAGE]) begin
            r_level   <= n_level;
            r_out_inv <= r_pinv;
        end
    end

    assign o_valid       = r_vld[OUT_STAGE];
    assign o_level_db_q8 = $signed(r_level);
    assign o_invalid     = r_out_inv;

endmodule

// ===== design/rxl_sq_stage.sv =====
// One squaring stage of the fractional log2 chain, for numerator and denominator.
module rxl_sq_stage
    import rxl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_en,
    input  t_sq_item i_item,
    output t_sq_item o_item
);

    logic [2*MANT_W-1:0] sq_num;
    logic [2*MANT_W-1:0] sq_den;
    logic [MANT_W:0]     t_num;
    logic [MANT_W:0]     t_den;
    t_sq_item            n_item;
    t_sq_item            r_item;

    always_comb begin
        sq_num = i_item.m_num * i_item.m_num;
        sq_den = i_item.m_den * i_item.m_den;
        t_num  = sq_num[2*MANT_W-1:MANT_W-1];
        t_den  = sq_den[2*MANT_W-1:MANT_W-1];

        n_item       = i_item;
        // a square at or above two yields a one bit and halves the mantissa
        n_item.f_num = {i_item.f_num[LOG_FRAC_BITS-2:0], t_num[MANT_W]};
        n_item.f_den = {i_item.f_den[LOG_FRAC_BITS-2:0], t_den[MANT_W]};
        n_item.m_num = t_num[MANT_W] ? t_num[MANT_W:1] : t_num[MANT_W-1:0];
        n_item.m_den = t_den[MANT_W] ? t_den[MANT_W:1] : t_den[MANT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule
